FILE: sv/assert_macros.svh
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk outside reset.
`define TSSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition implies another condition in the following cycle.
`define TSSP_ASSERT_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) else $error(msg);

`endif

FILE: sv/tssp_pkg.sv
`default_nettype none
package tssp_pkg;

  // Width of every request field.
  localparam int FIELD_W = 9;
  // Width of the result field.
  localparam int OUT_W = 31;

  // Controller states, one-hot.
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CLEAR = 8'b0000_0010,
    ST_DIVN  = 8'b0000_0100,
    ST_TRIAL = 8'b0000_1000,
    ST_DIVP  = 8'b0001_0000,
    ST_PASS  = 8'b0010_0000,
    ST_ACC   = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  // Request to the fraction divider: quotient of num / den, num < den.
  typedef struct packed {
    logic               start;
    logic [FIELD_W-1:0] num;
    logic [FIELD_W-1:0] den;
  } div_req_t;

endpackage
`default_nettype wire

FILE: sv/tssp_div.sv
`default_nettype none
// Restoring divider: floor(num * 2^FRAC_BITS / den), one quotient bit per cycle.
module tssp_div
  import tssp_pkg::*;
#(
  parameter int FRAC_BITS = 30
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire div_req_t             req,
  output logic                      done,
  output logic [FRAC_BITS-1:0]      quot
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [FIELD_W:0]     rem_r, rem_nxt;
  logic [FIELD_W-1:0]   den_r, den_nxt;
  logic [FRAC_BITS-1:0] quot_r, quot_nxt;
  logic [FIELD_W+1:0]   rem_sh;

  // One shift-and-subtract step per cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    rem_sh   = {rem_r, 1'b0};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = {1'b0, req.num};
      den_nxt  = req.den;
      quot_nxt = '0;
    end else if (busy_r) begin
      if (rem_sh >= {2'b00, den_r}) begin
        rem_nxt  = (FIELD_W + 1)'(rem_sh - {2'b00, den_r});
        quot_nxt = {quot_r[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[FIELD_W:0];
        quot_nxt = {quot_r[FRAC_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(FRAC_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule
`default_nettype wire

FILE: sv/threshold_selection_success_prob.sv
`default_nettype none
// Computes the success probability of a threshold selection rule as a
// Poisson-binomial cumulative distribution, one request at a time. A request
// is taken when start is high and busy is low; the single result appears on
// out_success_prob for exactly one cycle with out_valid, and the receiver
// cannot stall it, so it must capture the value in that cycle. A request first
// clears a row of min(rank, MAX_ITEMS) entries and divides 1/n, with n the
// saturated item count (the divide is skipped when n is one); then for each
// trial from sample_size+1 to n it makes a read-modify-write pass over the
// row memory, preceded by a serial division while rank is below the trial
// index, and a final state presents the result. The row memory pass handles
// one entry per cycle on a single read and single write port. Requests with
// nothing to do answer with zero.
module threshold_selection_success_prob
  import tssp_pkg::*;
#(
  parameter int MAX_ITEMS = 256,
  parameter int FRAC_BITS = 30
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [FIELD_W-1:0]  in_total_items,
  input  wire logic [FIELD_W-1:0]  in_rank,
  input  wire logic [FIELD_W-1:0]  in_sample_size,
  output logic                     out_valid,
  output logic [OUT_W-1:0]         out_success_prob
);

`include "assert_macros.svh"

  localparam int AW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int LW  = $clog2(MAX_ITEMS + 1);
  localparam int CW  = (LW > FIELD_W) ? LW : FIELD_W;
  localparam int EW  = FRAC_BITS + 2;
  localparam int PRW = FRAC_BITS + 1;
  localparam int SW  = FRAC_BITS + 3;
  localparam int MW  = EW + PRW;
  localparam int AMW = PRW + SW;

  localparam logic [EW-1:0]  ONE_E  = EW'(1) << FRAC_BITS;
  localparam logic [PRW-1:0] ONE_P  = PRW'(1) << FRAC_BITS;
  localparam logic [SW-1:0]  ONE_S  = SW'(1) << FRAC_BITS;
  localparam logic [MW:0]    HALF_M = (MW + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [AMW:0]   HALF_A = (AMW + 1)'(1) << (FRAC_BITS - 1);

  state_t               state_r, state_nxt;
  logic [FIELD_W-1:0]   n_r, n_nxt, k_r, k_nxt, s_r, s_nxt, i_r, i_nxt;
  logic [LW-1:0]        len_r, len_nxt;
  logic [LW-1:0]        clr_idx_r, clr_idx_nxt, rd_idx_r, rd_idx_nxt;
  logic                 rd_vld_r, rd_vld_nxt, st_vld_r, st_vld_nxt;
  logic [AW-1:0]        da_r, da_nxt, wr_addr_r, wr_addr_nxt;
  logic [PRW-1:0]       inv_r, inv_nxt, p_r, p_nxt, q_w;
  logic [EW-1:0]        prev_r, prev_nxt;
  logic [SW-1:0]        sum_r, sum_nxt, total_r, total_nxt;
  logic [OUT_W-1:0]     out_r, out_nxt;
  logic [MW-1:0]        prod_a_r, prod_a_nxt, prod_b_r, prod_b_nxt;
  div_req_t             div_req_r, div_req_nxt;
  logic                 div_done;
  logic [FRAC_BITS-1:0] div_quot;

  // Row memory.
  logic [EW-1:0]        mem [MAX_ITEMS];
  logic [EW-1:0]        mem_q_r;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa, mem_ra;
  logic [EW-1:0]        mem_wd;

  // Request decode.
  logic [CW-1:0]        n_ext, k_ext, n_sat, len_sat;
  logic [FIELD_W-1:0]   n_eff;
  logic [MW:0]          rnd_a, rnd_b;
  logic [AMW-1:0]       acc_prod;
  logic [AMW:0]         acc_rnd;
  logic [SW-1:0]        total_sat;
  logic [SW+OUT_W-1:0]  total_ext;
  logic                 issue;

  assign n_ext   = CW'(in_total_items);
  assign k_ext   = CW'(in_rank);
  assign n_sat   = (n_ext > CW'(MAX_ITEMS)) ? CW'(MAX_ITEMS) : n_ext;
  assign len_sat = (k_ext > CW'(MAX_ITEMS)) ? CW'(MAX_ITEMS) : k_ext;
  assign n_eff   = n_sat[FIELD_W-1:0];

  assign q_w      = ONE_P - p_r;
  assign rnd_a    = {1'b0, prod_a_r} + HALF_M;
  assign rnd_b    = {1'b0, prod_b_r} + HALF_M;
  assign acc_prod = inv_r * sum_r;
  assign acc_rnd  = {1'b0, acc_prod} + HALF_A;
  assign issue    = (rd_idx_r != len_r);
  assign mem_ra   = rd_idx_r[AW-1:0];

  // Fraction divider shared by 1/n and k/i.
  tssp_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req_r),
    .done (div_done),
    .quot (div_quot)
  );

  // Sequencer.
  always_comb begin
    state_nxt       = state_r;
    n_nxt           = n_r;
    k_nxt           = k_r;
    s_nxt           = s_r;
    i_nxt           = i_r;
    len_nxt         = len_r;
    clr_idx_nxt     = clr_idx_r;
    rd_idx_nxt      = rd_idx_r;
    rd_vld_nxt      = 1'b0;
    st_vld_nxt      = 1'b0;
    da_nxt          = da_r;
    wr_addr_nxt     = wr_addr_r;
    inv_nxt         = inv_r;
    p_nxt           = p_r;
    prev_nxt        = prev_r;
    sum_nxt         = sum_r;
    total_nxt       = total_r;
    out_nxt         = out_r;
    div_req_nxt     = div_req_r;
    div_req_nxt.start = 1'b0;
    mem_we          = 1'b0;
    mem_wa          = wr_addr_r;
    mem_wd          = '0;
    total_sat       = '0;
    total_ext       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          n_nxt     = n_eff;
          k_nxt     = in_rank;
          s_nxt     = in_sample_size;
          len_nxt   = len_sat[LW-1:0];
          total_nxt = '0;
          clr_idx_nxt = '0;
          if (n_eff == '0 || in_sample_size >= n_eff || len_sat == '0) begin
            out_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        // Row starts as certainty of zero successes.
        mem_we      = 1'b1;
        mem_wa      = clr_idx_r[AW-1:0];
        mem_wd      = (clr_idx_r == '0) ? ONE_E : '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == len_r - 1'b1) begin
          i_nxt = s_r + 1'b1;
          if (n_r == FIELD_W'(1)) begin
            inv_nxt   = ONE_P;
            state_nxt = ST_TRIAL;
          end else begin
            div_req_nxt.start = 1'b1;
            div_req_nxt.num   = FIELD_W'(1);
            div_req_nxt.den   = n_r;
            state_nxt         = ST_DIVN;
          end
        end
      end
      ST_DIVN: begin
        if (div_done) begin
          inv_nxt   = {1'b0, div_quot};
          state_nxt = ST_TRIAL;
        end
      end
      ST_TRIAL: begin
        sum_nxt    = '0;
        rd_idx_nxt = '0;
        prev_nxt   = '0;
        if (k_r >= i_r) begin
          p_nxt     = ONE_P;
          state_nxt = ST_PASS;
        end else begin
          div_req_nxt.start = 1'b1;
          div_req_nxt.num   = k_r;
          div_req_nxt.den   = i_r;
          state_nxt         = ST_DIVP;
        end
      end
      ST_DIVP: begin
        if (div_done) begin
          p_nxt     = {1'b0, div_quot};
          state_nxt = ST_PASS;
        end
      end
      ST_PASS: begin
        // Read stage.
        if (issue) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
          da_nxt     = rd_idx_r[AW-1:0];
        end
        rd_vld_nxt = issue;
        // Data stage: old values feed the sum and the fold.
        if (rd_vld_r) begin
          sum_nxt     = sum_r + SW'(mem_q_r);
          prev_nxt    = mem_q_r;
          wr_addr_nxt = da_r;
        end
        st_vld_nxt = rd_vld_r;
        // Write-back stage.
        if (st_vld_r) begin
          mem_we = 1'b1;
          mem_wa = wr_addr_r;
          mem_wd = rnd_a[FRAC_BITS +: EW] + rnd_b[FRAC_BITS +: EW];
        end
        if (!issue && !rd_vld_r && !st_vld_r) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        total_nxt = total_r + acc_rnd[FRAC_BITS +: SW];
        if (i_r == n_r) begin
          total_sat = (total_nxt > ONE_S) ? ONE_S : total_nxt;
          total_ext = {{OUT_W{1'b0}}, total_sat};
          out_nxt   = total_ext[OUT_W-1:0];
          state_nxt = ST_DONE;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_TRIAL;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Fold products of the data stage.
  assign prod_a_nxt = mem_q_r * q_w;
  assign prod_b_nxt = prev_r * p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_vld_r  <= 1'b0;
      st_vld_r  <= 1'b0;
      div_req_r <= '0;
      total_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_vld_r  <= rd_vld_nxt;
      st_vld_r  <= st_vld_nxt;
      div_req_r <= div_req_nxt;
      total_r   <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    k_r       <= k_nxt;
    s_r       <= s_nxt;
    i_r       <= i_nxt;
    len_r     <= len_nxt;
    clr_idx_r <= clr_idx_nxt;
    rd_idx_r  <= rd_idx_nxt;
    da_r      <= da_nxt;
    wr_addr_r <= wr_addr_nxt;
    inv_r     <= inv_nxt;
    p_r       <= p_nxt;
    prev_r    <= prev_nxt;
    sum_r     <= sum_nxt;
    out_r     <= out_nxt;
    prod_a_r  <= prod_a_nxt;
    prod_b_r  <= prod_b_nxt;
  end

  // Row memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= mem[mem_ra];
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = (state_r == ST_DONE);
  assign out_success_prob = out_r;

  // Checks.
  `TSSP_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted transfer did not raise busy")
  `TSSP_ASSERT_NEXT(a_done_idle, out_valid, !busy && !out_valid, "result strobe not single")
  `TSSP_ASSERT(a_we_state, mem_we |-> (state_r == ST_CLEAR || state_r == ST_PASS),
    "row memory written outside clear or pass")
  `TSSP_ASSERT(a_out_range, out_valid |-> (SW'(out_success_prob) <= ONE_S),
    "result above one")

endmodule
`default_nettype wire

FILE: tb/threshold_selection_success_prob_tb.sv
`default_nettype none
module threshold_selection_success_prob_tb;
  import tssp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_DEPTH = 256;
  localparam int QBITS = 30;
  localparam logic [63:0] UNITY = 64'd1 << QBITS;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [FIELD_W-1:0] in_total_items;
  logic [FIELD_W-1:0] in_rank;
  logic [FIELD_W-1:0] in_sample_size;
  logic out_valid;
  logic [OUT_W-1:0] out_success_prob;

  logic [OUT_W-1:0] expected_prob_q[$];
  int fail_count;

  threshold_selection_success_prob DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_total_items(in_total_items),
    .in_rank(in_rank),
    .in_sample_size(in_sample_size),
    .out_valid(out_valid),
    .out_success_prob(out_success_prob)
  );

  // Clock with a 4 ns period.
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Truncated fraction num / den scaled by one, for num < den.
  function automatic logic [63:0] frac_quotient(logic [63:0] num, logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = num;
    quo = 0;
    for (int b = 0; b < QBITS; b++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Fixed-point product, rounded to nearest with halves going up.
  function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    prod = prod + (128'd1 << (QBITS - 1));
    return prod[QBITS +: 64];
  endfunction

  // Success probability of one request via the in-place distribution row.
  function automatic logic [OUT_W-1:0] success_prob(logic [FIELD_W-1:0] n_in,
                                                    logic [FIELD_W-1:0] k_in,
                                                    logic [FIELD_W-1:0] s_in);
    logic [63:0] row_prob[ROW_DEPTH];
    logic [63:0] total;
    logic [63:0] inv_n;
    logic [63:0] acc;
    logic [63:0] p;
    logic [63:0] q;
    int n;
    int len;
    n = (n_in > ROW_DEPTH) ? ROW_DEPTH : n_in;
    len = (k_in > ROW_DEPTH) ? ROW_DEPTH : k_in;
    for (int j = 0; j < ROW_DEPTH; j++) row_prob[j] = 0;
    total = 0;
    if (len > 0) row_prob[0] = UNITY;
    if (n >= 1 && s_in < n) begin
      inv_n = (n == 1) ? UNITY : frac_quotient(1, n);
      for (int i = s_in + 1; i <= n; i++) begin
        acc = 0;
        for (int j = 0; j < len; j++) acc += row_prob[j];
        total += fx_mul(inv_n, acc);
        p = (k_in >= i) ? UNITY : frac_quotient(k_in, i);
        q = UNITY - p;
        for (int j = len; j > 1; j--)
          row_prob[j-1] = fx_mul(row_prob[j-1], q) + fx_mul(row_prob[j-2], p);
        if (len > 0) row_prob[0] = fx_mul(row_prob[0], q);
      end
    end
    if (total > UNITY) total = UNITY;
    return total[OUT_W-1:0];
  endfunction

  // Record an expectation per request transfer and check each result strobe.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy)
        expected_prob_q = {expected_prob_q,
                           success_prob(in_total_items, in_rank, in_sample_size)};
      if (out_valid) begin
        if (expected_prob_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d",
                   $time, out_success_prob);
          fail_count++;
        end else begin
          if (out_success_prob !== expected_prob_q[0]) begin
            $display("%0t: success_prob mismatch, expected %0d, actual %0d",
                     $time, expected_prob_q[0], out_success_prob);
            fail_count++;
          end
          void'(expected_prob_q.pop_front());
        end
      end
    end
  end

  // Present one request and hold it until the block takes it.
  task automatic send_request(logic [FIELD_W-1:0] n, logic [FIELD_W-1:0] k,
                              logic [FIELD_W-1:0] s);
    start <= 1'b1;
    in_total_items <= n;
    in_rank <= k;
    in_sample_size <= s;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Drop start for a random idle gap with the given percent chance.
  task automatic maybe_idle(int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // Directed rows: n, k, sample, whether the result is known, known result.
  typedef struct {
    int n;
    int k;
    int s;
    bit known;
    int prob;
  } directed_row_t;

  directed_row_t directed_rows[] = '{
    '{0, 5, 0, 1, 0},
    '{0, 0, 0, 1, 0},
    '{5, 0, 0, 1, 0},
    '{5, 3, 5, 1, 0},
    '{5, 3, 9, 1, 0},
    '{511, 511, 511, 1, 0},
    '{1, 1, 0, 1, 1073741824},
    '{1, 511, 0, 1, 1073741824},
    '{2, 1, 0, 0, 0},
    '{2, 2, 0, 0, 0},
    '{10, 1, 3, 0, 0},
    '{10, 4, 0, 0, 0},
    '{10, 10, 9, 0, 0},
    '{17, 300, 2, 0, 0},
    '{256, 1, 100, 0, 0},
    '{256, 256, 0, 0, 0},
    '{400, 2, 250, 0, 0},
    '{511, 256, 254, 0, 0},
    '{300, 5, 255, 0, 0},
    '{37, 6, 0, 0, 0}
  };

  initial begin
    logic [FIELD_W-1:0] n;
    logic [FIELD_W-1:0] k;
    logic [FIELD_W-1:0] s;
    int sel;
    int idle_pct;
    fail_count = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_total_items = '0;
    in_rank = '0;
    in_sample_size = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table; rows with a known value cross-check the predictor too.
    foreach (directed_rows[r]) begin
      n = FIELD_W'(directed_rows[r].n);
      k = FIELD_W'(directed_rows[r].k);
      s = FIELD_W'(directed_rows[r].s);
      if (directed_rows[r].known &&
          success_prob(n, k, s) !== directed_rows[r].prob[OUT_W-1:0]) begin
        $display("%0t: table row %0d, expected %0d, actual %0d", $time, r,
                 directed_rows[r].prob, success_prob(n, k, s));
        fail_count++;
      end
      send_request(n, k, s);
      maybe_idle(20);
    end

    // Let the block drain completely before the random traffic.
    start <= 1'b0;
    while (expected_prob_q.size() != 0) @(negedge clk);

    // Random traffic in three phases of sender idling.
    for (int item = 0; item < 100; item++) begin
      idle_pct = (item < 33) ? 33 : (item < 66) ? 49 : 0;
      sel = $urandom_range(99);
      if (sel < 8) begin
        n = FIELD_W'($urandom_range(0, 511));
        k = FIELD_W'($urandom_range(0, 511));
        s = FIELD_W'($urandom_range(0, 511));
      end else if (sel < 12) begin
        n = FIELD_W'($urandom_range(200, 256));
        k = FIELD_W'($urandom_range(1, 511));
        s = FIELD_W'($urandom_range(0, 120));
      end else begin
        n = FIELD_W'($urandom_range(1, 40));
        k = FIELD_W'($urandom_range(1, n + 2));
        s = FIELD_W'($urandom_range(0, n));
      end
      maybe_idle(idle_pct);
      send_request(n, k, s);
    end
    start <= 1'b0;

    // Drain the remaining results, then allow a quiet tail.
    while (expected_prob_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0 && expected_prob_q.size() == 0) begin
      $display("PASS threshold_selection_success_prob");
    end else begin
      $display("FAIL threshold_selection_success_prob");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #400_000_000;
    $display("FAIL threshold_selection_success_prob");
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
+incdir+sv
sv/tssp_pkg.sv
sv/tssp_div.sv
sv/threshold_selection_success_prob.sv
tb/threshold_selection_success_prob_tb.sv
